// ===== src/fdms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdms_pkg;

   localparam int PIXEL_W   = 8;
   localparam int SIZE_W    = 11;
   localparam int SUM_W     = 36;
   localparam int SQ_W      = 2 * PIXEL_W;
   localparam int CSR_IDX_W = 2;
   localparam int QDEPTH    = 8;
   localparam int QPTR_W    = 3;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

   // floor(x / 3) for x < 1024 as (x * 683) >> 11
   localparam logic [9:0] DIV3_MUL   = 10'd683;
   localparam int         DIV3_SHIFT = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               include_req;
      logic               sampled;
      logic               primed;
      logic               last;
   } pix_item_type;

   typedef struct packed {
      logic            add;
      logic            last;
      logic [SQ_W-1:0] square;
   } diff_item_type;

   typedef struct packed {
      logic [SUM_W-1:0] frame_sum;
      logic [SUM_W-1:0] filtered_sum;
   } result_type;

   function automatic logic [PIXEL_W-1:0] div3(input logic [9:0] x);
      logic [19:0] prod;
      prod = {10'd0, x} * {10'd0, DIV3_MUL};
      return prod[DIV3_SHIFT +: PIXEL_W];
   endfunction

endpackage

`default_nettype wire

// ===== src/fdms_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdms_scan #(
   parameter int MAX_WIDTH   = 1920,
   parameter int MAX_HEIGHT  = 1080,
   parameter int SAMPLE_STEP = 10,
   parameter int ADDR_W      = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire logic [fdms_pkg::PIXEL_W-1:0]   pixel,
   input  wire logic                           include_req,
   input  wire logic                           csr_write,
   input  wire logic [fdms_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fdms_pkg::SIZE_W-1:0]    csr_wdata,
   output fdms_pkg::pix_item_type              item,
   output logic      [ADDR_W-1:0]              addr,
   output logic                                frame_last,
   output logic                                restart
);
   import fdms_pkg::*;

   localparam int COLS    = (MAX_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
   localparam int PHASE_W = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLE_STEP - 1);
   localparam logic [ADDR_W-1:0]  ROW_STRIDE = ADDR_W'(COLS);

   logic [SIZE_W-1:0]  column_ff, column_in, row_ff, row_in;
   logic [PHASE_W-1:0] col_phase_ff, col_phase_in, row_phase_ff, row_phase_in;
   logic [ADDR_W-1:0]  col_idx_ff, col_idx_in, row_base_ff, row_base_in;
   logic               primed_ff, primed_in;
   logic [SIZE_W-1:0]  frame_width_ff, frame_width_in, frame_height_ff, frame_height_in;
   logic [SIZE_W-1:0]  w_eff, h_eff;
   logic               col_last, row_last, in_range, size_change;

   always_comb begin
      w_eff      = (frame_width_ff == '0) ? SIZE_W'(1) : frame_width_ff;
      h_eff      = (frame_height_ff == '0) ? SIZE_W'(1) : frame_height_ff;
      col_last   = ({1'b0, column_ff} + (SIZE_W + 1)'(1)) >= {1'b0, w_eff};
      row_last   = ({1'b0, row_ff} + (SIZE_W + 1)'(1)) >= {1'b0, h_eff};
      frame_last = col_last && row_last;
      in_range   = (32'(column_ff) < MAX_WIDTH) && (32'(row_ff) < MAX_HEIGHT);

      item.pixel       = pixel;
      item.include_req = include_req;
      item.sampled     = in_range && (col_phase_ff == '0) && (row_phase_ff == '0);
      item.primed      = primed_ff;
      item.last        = frame_last;
      addr             = row_base_ff + col_idx_ff;

      size_change = 1'b0;
      case (csr_index)
         CSR_FRAME_WIDTH:  size_change = csr_write && (csr_wdata != frame_width_ff);
         CSR_FRAME_HEIGHT: size_change = csr_write && (csr_wdata != frame_height_ff);
         default:          size_change = 1'b0;
      endcase
      restart = size_change;
   end

   always_comb begin
      column_in       = column_ff;
      row_in          = row_ff;
      col_phase_in    = col_phase_ff;
      row_phase_in    = row_phase_ff;
      col_idx_in      = col_idx_ff;
      row_base_in     = row_base_ff;
      primed_in       = primed_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
         // restart priming from the top of a frame
         if (size_change) begin
            column_in    = '0;
            row_in       = '0;
            col_phase_in = '0;
            row_phase_in = '0;
            col_idx_in   = '0;
            row_base_in  = '0;
            primed_in    = 1'b0;
         end
      end else if (fire) begin
         if (col_last) begin
            column_in    = '0;
            col_phase_in = '0;
            col_idx_in   = '0;
            if (row_last) begin
               row_in       = '0;
               row_phase_in = '0;
               row_base_in  = '0;
               primed_in    = 1'b1;
            end else begin
               row_in = row_ff + SIZE_W'(1);
               if (row_phase_ff == PHASE_LAST) begin
                  row_phase_in = '0;
                  row_base_in  = row_base_ff + ROW_STRIDE;
               end else begin
                  row_phase_in = row_phase_ff + PHASE_W'(1);
               end
            end
         end else begin
            column_in = column_ff + SIZE_W'(1);
            if (col_phase_ff == PHASE_LAST) begin
               col_phase_in = '0;
               col_idx_in   = col_idx_ff + ADDR_W'(1);
            end else begin
               col_phase_in = col_phase_ff + PHASE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         row_ff          <= '0;
         col_phase_ff    <= '0;
         row_phase_ff    <= '0;
         col_idx_ff      <= '0;
         row_base_ff     <= '0;
         primed_ff       <= 1'b0;
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else begin
         column_ff       <= column_in;
         row_ff          <= row_in;
         col_phase_ff    <= col_phase_in;
         row_phase_ff    <= row_phase_in;
         col_idx_ff      <= col_idx_in;
         row_base_ff     <= row_base_in;
         primed_ff       <= primed_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/fdms_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdms_update #(
   parameter int DEPTH  = 20736,
   parameter int ADDR_W = 15
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  fdms_pkg::pix_item_type   a_item,
   input  wire logic [ADDR_W-1:0]   a_addr,
   output logic                     c_valid,
   output fdms_pkg::diff_item_type  c_item
);
   import fdms_pkg::*;

   logic [PIXEL_W-1:0] bg_mem [DEPTH];

   logic               b_valid_ff;
   pix_item_type       b_item_ff;
   logic [ADDR_W-1:0]  b_addr_ff;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               wr_en_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   logic [PIXEL_W-1:0] wr_data_ff;
   logic               c_valid_ff;
   diff_item_type      c_item_ff, c_item_in;

   logic [PIXEL_W-1:0] bg, diff, blend, wr_data;
   logic               wr_en;

   always_comb begin
      // take the value written on the edge of our own read
      bg      = (wr_en_ff && (wr_addr_ff == b_addr_ff)) ? wr_data_ff : rd_data_ff;
      diff    = (b_item_ff.pixel > bg) ? (b_item_ff.pixel - bg) : (bg - b_item_ff.pixel);
      blend   = div3({1'b0, bg, 1'b0} + {2'b00, b_item_ff.pixel});
      wr_en   = b_valid_ff && b_item_ff.sampled &&
                (!b_item_ff.primed || b_item_ff.include_req);
      wr_data = b_item_ff.primed ? blend : b_item_ff.pixel;

      c_item_in.add    = b_valid_ff && b_item_ff.sampled && b_item_ff.primed &&
                         b_item_ff.include_req;
      c_item_in.last   = b_item_ff.last;
      c_item_in.square = {{PIXEL_W{1'b0}}, diff} * {{PIXEL_W{1'b0}}, diff};
   end

   always_ff @(posedge clock) begin
      if (fire && a_item.sampled) begin
         rd_data_ff <= bg_mem[a_addr];
      end
      if (wr_en) begin
         bg_mem[b_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         wr_en_ff   <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= fire;
         wr_en_ff   <= wr_en;
         c_valid_ff <= b_valid_ff;
      end
      if (fire) begin
         b_item_ff <= a_item;
         b_addr_ff <= a_addr;
      end
      wr_addr_ff <= b_addr_ff;
      wr_data_ff <= wr_data;
      c_item_ff  <= c_item_in;
   end

   assign c_valid = c_valid_ff;
   assign c_item  = c_item_ff;

endmodule

`default_nettype wire

// ===== src/fdms_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdms_accum (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               restart,
   input  wire logic               c_valid,
   input  fdms_pkg::diff_item_type c_item,
   output logic                    push,
   output fdms_pkg::result_type    push_data
);
   import fdms_pkg::*;

   localparam int TOT_W = SUM_W + 4;

   logic [SUM_W-1:0] partial_ff, partial_in;
   logic             d_valid_ff;
   logic [SUM_W-1:0] d_sum_ff, running_ff;
   logic [SUM_W:0]   ext;
   logic [SUM_W-1:0] sum_now;
   logic [TOT_W-1:0] total;

   always_comb begin
      ext     = {1'b0, partial_ff} +
                (c_item.add ? (SUM_W + 1)'(c_item.square) : '0);
      sum_now = ext[SUM_W] ? '1 : ext[SUM_W-1:0];

      partial_in = partial_ff;
      if (restart) begin
         partial_in = '0;
      end else if (c_valid) begin
         partial_in = c_item.last ? '0 : sum_now;
      end

      // 15 * running + sum, then drop four bits
      total = {running_ff, 4'b0000} - {4'b0000, running_ff} + {4'b0000, d_sum_ff};

      push                   = d_valid_ff;
      push_data.frame_sum    = d_sum_ff;
      push_data.filtered_sum = total[TOT_W-1:4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         d_valid_ff <= 1'b0;
         running_ff <= '0;
      end else begin
         partial_ff <= partial_in;
         d_valid_ff <= c_valid && c_item.last;
         if (d_valid_ff) begin
            running_ff <= total[TOT_W-1:4];
         end
      end
      if (c_valid && c_item.last) begin
         d_sum_ff <= sum_now;
      end
   end

endmodule

`default_nettype wire

// ===== src/fdms_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdms_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            reserve,
   input  wire logic            push,
   input  fdms_pkg::result_type push_data,
   input  wire logic            pop,
   output logic                 room,
   output logic                 valid,
   output fdms_pkg::result_type head
);
   import fdms_pkg::*;

   result_type        store [QDEPTH];
   logic [QPTR_W:0]   wr_ptr_ff, rd_ptr_ff, pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      case ({reserve, pop})
         2'b10:   pending_in = pending_ff + (QPTR_W + 1)'(1);
         2'b01:   pending_in = pending_ff - (QPTR_W + 1)'(1);
         default: pending_in = pending_ff;
      endcase
      room  = pending_ff < (QPTR_W + 1)'(QDEPTH);
      valid = wr_ptr_ff != rd_ptr_ff;
      head  = store[rd_ptr_ff[QPTR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + (QPTR_W + 1)'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + (QPTR_W + 1)'(1);
         end
      end
      if (push) begin
         store[wr_ptr_ff[QPTR_W-1:0]] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/frame_difference_motion_score_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Motion score from frame differencing: gray pixels enter in raster order, one item per
// clock while req_ready is high, and every SAMPLE_STEP-th column of every SAMPLE_STEP-th
// row is compared with a background held in a single-write-port, registered-read memory
// of ceil(MAX_WIDTH/SAMPLE_STEP) * ceil(MAX_HEIGHT/SAMPLE_STEP) bytes, which is read on
// acceptance and written back the next cycle (a same-entry hit is forwarded). The frame
// sum and filtered sum pass through the update stages and a sum register after the last
// pixel of a frame is accepted and wait in an eight-deep result queue; req_ready drops
// only for the last pixel of a frame while eight results are still outstanding. The first
// frame after reset or a size change primes the background and reports a frame sum of
// zero. Frame size registers may only be written while no item is in flight.

module frame_difference_motion_score_core #(
   parameter int MAX_WIDTH   = 1920,
   parameter int MAX_HEIGHT  = 1080,
   parameter int SAMPLE_STEP = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [fdms_pkg::PIXEL_W-1:0]   req_pixel,
   input  wire logic                           req_include_req,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [fdms_pkg::SUM_W-1:0]     rsp_frame_sum,
   output logic      [fdms_pkg::SUM_W-1:0]     rsp_filtered_sum,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fdms_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fdms_pkg::SIZE_W-1:0]    csr_wdata
);
   import fdms_pkg::*;

   localparam int COLS   = (MAX_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
   localparam int ROWS   = (MAX_HEIGHT + SAMPLE_STEP - 1) / SAMPLE_STEP;
   localparam int DEPTH  = COLS * ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   pix_item_type      a_item;
   logic [ADDR_W-1:0] a_addr;
   logic              frame_last, restart, fire, room;
   logic              c_valid, push;
   diff_item_type     c_item;
   result_type        push_data, head;

   assign fire      = req_valid && req_ready;
   assign req_ready = room || !frame_last;
   assign csr_ready = 1'b1;

   fdms_scan #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .SAMPLE_STEP (SAMPLE_STEP),
      .ADDR_W      (ADDR_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .pixel       (req_pixel),
      .include_req (req_include_req),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item        (a_item),
      .addr        (a_addr),
      .frame_last  (frame_last),
      .restart     (restart)
   );

   fdms_update #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_update (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .a_item  (a_item),
      .a_addr  (a_addr),
      .c_valid (c_valid),
      .c_item  (c_item)
   );

   fdms_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .c_valid   (c_valid),
      .c_item    (c_item),
      .push      (push),
      .push_data (push_data)
   );

   fdms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .reserve   (fire && frame_last),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_valid && rsp_ready),
      .room      (room),
      .valid     (rsp_valid),
      .head      (head)
   );

   assign rsp_frame_sum    = head.frame_sum;
   assign rsp_filtered_sum = head.filtered_sum;

endmodule

`default_nettype wire

// ===== src/fdms_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdms_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       csr_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [fdms_pkg::SUM_W-1:0] rsp_frame_sum,
   input wire logic [fdms_pkg::SUM_W-1:0] rsp_filtered_sum
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_frame_sum) && $stable(rsp_filtered_sum))
      else $error("stalled result item changed or dropped");

   a_rsp_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item present straight after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready && csr_ready)
      else $error("block not ready straight after reset");

endmodule

bind frame_difference_motion_score_core fdms_checker u_checker (.*);

`default_nettype wire
